// File: hw/rtl/decimal_seven_segment_frame_writer_core_macros.svh
// Assertion macros used by the frame writer core.
`ifndef DECIMAL_SEVEN_SEGMENT_FRAME_WRITER_CORE_MACROS_SVH
`define DECIMAL_SEVEN_SEGMENT_FRAME_WRITER_CORE_MACROS_SVH

`ifndef SYNTH
`define DSSFW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("frame writer check failed");
`define DSSFW_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("frame writer forbidden condition seen");
`else
`define DSSFW_ASSERT(lbl, clk, rst_n, prop)
`define DSSFW_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

// File: hw/rtl/dssfw_pkg.sv
package dssfw_pkg;

  localparam int unsigned QUEUE_DEPTH = 8;

  localparam int unsigned NUM_DIGITS = 4;
  localparam logic [2:0]  MAX_COUNT  = 3'd4;

  // Reciprocal of 1000 that is exact for every 16-bit dividend.
  localparam logic [16:0] DIV1000_MUL   = 17'd67109;
  localparam int unsigned DIV1000_SHIFT = 26;

  localparam logic [1:0] CFG_BRIGHTNESS  = 2'd0;
  localparam logic [1:0] CFG_DATA_CMD    = 2'd1;
  localparam logic [1:0] CFG_ADDRESS_CMD = 2'd2;
  localparam logic [1:0] CFG_DISPLAY_CMD = 2'd3;

  localparam logic [7:0] SEG_ZERO = 8'h3F;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  typedef struct packed {
    logic [3:0] brightness;
    logic [7:0] data_cmd;
    logic [7:0] address_cmd;
    logic [7:0] display_cmd;
  } cfg_t;

  typedef struct packed {
    logic [NUM_DIGITS-1:0][7:0] segs;
    logic [2:0]                 count;
    logic [1:0]                 pos;
  } digit_word_t;

  typedef enum logic [1:0] {
    BK_DATA,
    BK_ADDR,
    BK_DIGIT,
    BK_DISP
  } back_state_e;

  function automatic logic [7:0] seg_glyph(input logic [3:0] digit);
    logic [7:0] glyph;
    unique case (digit)
      4'h0: glyph = 8'h3F;
      4'h1: glyph = 8'h06;
      4'h2: glyph = 8'h5B;
      4'h3: glyph = 8'h4F;
      4'h4: glyph = 8'h66;
      4'h5: glyph = 8'h6D;
      4'h6: glyph = 8'h7D;
      4'h7: glyph = 8'h07;
      4'h8: glyph = 8'h7F;
      4'h9: glyph = 8'h6F;
      4'hA: glyph = 8'h77;
      4'hB: glyph = 8'h7C;
      4'hC: glyph = 8'h39;
      4'hD: glyph = 8'h5E;
      4'hE: glyph = 8'h79;
      4'hF: glyph = 8'h71;
    endcase
    return glyph;
  endfunction

endpackage

// File: hw/rtl/dssfw_front.sv
module dssfw_front #(
  parameter int unsigned QueueDepth = dssfw_pkg::QUEUE_DEPTH,
  localparam int unsigned CreditW = $clog2(QueueDepth + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [15:0]               number_i,
  input  logic                      show_leading_zeros_i,
  input  logic [2:0]                digit_count_i,
  input  logic [1:0]                first_position_i,
  input  logic                      pop_i,
  output logic                      push_o,
  output dssfw_pkg::digit_word_t    push_word_o,
  output logic [CreditW-1:0]        credit_o
);

  logic               accept;
  logic [32:0]        quo_prod;
  logic [2:0]         count_sat;
  logic [CreditW-1:0] credit_q, credit_d;

  logic       a_valid_q;
  logic [15:0] a_num_q;
  logic [6:0] a_quo_q;
  logic       a_show_q;
  logic [2:0] a_count_q;
  logic [1:0] a_pos_q;

  logic [15:0] b_thou;
  logic [15:0] b_rem_full;
  logic       b_valid_q;
  logic [9:0] b_rem_q;
  logic [6:0] b_quo_q;
  logic       b_show_q;
  logic [2:0] b_count_q;
  logic [1:0] b_pos_q;

  logic [3:0] c_hund;
  logic [9:0] c_rem2_full;
  logic       c_valid_q;
  logic [3:0] c_hund_q;
  logic [6:0] c_rem2_q;
  logic [6:0] c_quo_q;
  logic       c_show_q;
  logic [2:0] c_count_q;
  logic [1:0] c_pos_q;

  logic [3:0] d_tens;
  logic [6:0] d_units_full;
  logic [dssfw_pkg::NUM_DIGITS-1:0][3:0] d_digit;
  logic [dssfw_pkg::NUM_DIGITS-1:0]      d_nonzero;
  logic [dssfw_pkg::NUM_DIGITS-1:0][7:0] d_segs;

  assign accept    = start && !busy;
  assign busy      = (credit_q == CreditW'(QueueDepth));
  assign credit_o  = credit_q;
  assign quo_prod  = {17'd0, number_i} * {16'd0, dssfw_pkg::DIV1000_MUL};
  assign count_sat = (digit_count_i > dssfw_pkg::MAX_COUNT) ? dssfw_pkg::MAX_COUNT
                                                            : digit_count_i;

  always_comb begin
    credit_d = credit_q;
    if (accept && !pop_i) begin
      credit_d = credit_q + CreditW'(1);
    end else if (!accept && pop_i) begin
      credit_d = credit_q - CreditW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q  <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      credit_q  <= credit_d;
      a_valid_q <= accept;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // The thousands quotient may exceed nine; it is kept whole for blanking.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_num_q   <= number_i;
      a_quo_q   <= quo_prod[dssfw_pkg::DIV1000_SHIFT +: 7];
      a_show_q  <= show_leading_zeros_i;
      a_count_q <= count_sat;
      a_pos_q   <= first_position_i;
    end
  end

  assign b_thou     = {9'd0, a_quo_q} * 16'd1000;
  assign b_rem_full = a_num_q - b_thou;

  always_ff @(posedge clk_i) begin
    b_rem_q   <= b_rem_full[9:0];
    b_quo_q   <= a_quo_q;
    b_show_q  <= a_show_q;
    b_count_q <= a_count_q;
    b_pos_q   <= a_pos_q;
  end

  always_comb begin
    c_hund = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (b_rem_q >= 10'(k * 100)) begin
        c_hund = 4'(k);
      end
    end
  end

  assign c_rem2_full = b_rem_q - ({6'd0, c_hund} * 10'd100);

  always_ff @(posedge clk_i) begin
    c_hund_q  <= c_hund;
    c_rem2_q  <= c_rem2_full[6:0];
    c_quo_q   <= b_quo_q;
    c_show_q  <= b_show_q;
    c_count_q <= b_count_q;
    c_pos_q   <= b_pos_q;
  end

  always_comb begin
    d_tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (c_rem2_q >= 7'(k * 10)) begin
        d_tens = 4'(k);
      end
    end
  end

  assign d_units_full = c_rem2_q - ({3'd0, d_tens} * 7'd10);

  always_comb begin
    logic leading;
    leading      = 1'b1;
    d_digit[0]   = c_quo_q[3:0];
    d_digit[1]   = c_hund_q;
    d_digit[2]   = d_tens;
    d_digit[3]   = d_units_full[3:0];
    d_nonzero[0] = (c_quo_q != 7'd0);
    d_nonzero[1] = (c_hund_q != 4'd0);
    d_nonzero[2] = (d_tens != 4'd0);
    d_nonzero[3] = (d_units_full[3:0] != 4'd0);
    for (int i = 0; i < dssfw_pkg::NUM_DIGITS; i++) begin
      if (d_nonzero[i]) begin
        d_segs[i] = dssfw_pkg::seg_glyph(d_digit[i]);
        leading   = 1'b0;
      end else if (c_show_q || !leading || (i == dssfw_pkg::NUM_DIGITS - 1)) begin
        d_segs[i] = dssfw_pkg::SEG_ZERO;
      end else begin
        d_segs[i] = dssfw_pkg::SEG_BLANK;
      end
    end
  end

  assign push_o            = c_valid_q;
  assign push_word_o.segs  = d_segs;
  assign push_word_o.count = c_count_q;
  assign push_word_o.pos   = c_pos_q;

endmodule

// File: hw/rtl/dssfw_queue.sv
module dssfw_queue #(
  parameter int unsigned QueueDepth = dssfw_pkg::QUEUE_DEPTH,
  localparam int unsigned AddrW = $clog2(QueueDepth),
  localparam int unsigned CountW = $clog2(QueueDepth + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  dssfw_pkg::digit_word_t push_word_i,
  input  logic                   pop_i,
  output logic                   not_empty_o,
  output dssfw_pkg::digit_word_t head_word_o
);

  dssfw_pkg::digit_word_t entry_q [QueueDepth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] fill_q, fill_d;

  assign not_empty_o = (fill_q != '0);
  assign head_word_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + CountW'(1);
    end else if (!push_i && pop_i) begin
      fill_d = fill_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

// File: hw/rtl/dssfw_back.sv
module dssfw_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dssfw_pkg::cfg_t        cfg_i,
  input  logic                   not_empty_i,
  input  dssfw_pkg::digit_word_t word_i,
  output logic                   pop_o,
  output logic                   strobe,
  output logic [7:0]             bus_byte_o,
  output logic                   open_frame_o,
  output logic                   close_frame_o,
  output logic                   last_o
);

  dssfw_pkg::back_state_e state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic [2:0] first_idx;

  logic       emit;
  logic [7:0] byte_d;
  logic       open_d;
  logic       close_d;
  logic       last_d;

  logic       strobe_q;
  logic [7:0] byte_q;
  logic       open_q;
  logic       close_q;
  logic       last_q;

  assign first_idx = dssfw_pkg::MAX_COUNT - word_i.count;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      dssfw_pkg::BK_DATA: begin
        if (not_empty_i) begin
          state_d = dssfw_pkg::BK_ADDR;
        end
      end
      dssfw_pkg::BK_ADDR: begin
        idx_d = first_idx[1:0];
        if (word_i.count == 3'd0) begin
          state_d = dssfw_pkg::BK_DISP;
        end else begin
          state_d = dssfw_pkg::BK_DIGIT;
        end
      end
      dssfw_pkg::BK_DIGIT: begin
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          state_d = dssfw_pkg::BK_DISP;
        end
      end
      dssfw_pkg::BK_DISP: begin
        state_d = dssfw_pkg::BK_DATA;
      end
    endcase
  end

  always_comb begin
    emit    = 1'b0;
    pop_o   = 1'b0;
    byte_d  = cfg_i.data_cmd;
    open_d  = 1'b1;
    close_d = 1'b1;
    last_d  = 1'b0;
    unique case (state_q)
      dssfw_pkg::BK_DATA: begin
        emit = not_empty_i;
      end
      dssfw_pkg::BK_ADDR: begin
        emit    = 1'b1;
        byte_d  = cfg_i.address_cmd + {6'd0, word_i.pos};
        close_d = (word_i.count == 3'd0);
      end
      dssfw_pkg::BK_DIGIT: begin
        emit    = 1'b1;
        byte_d  = word_i.segs[idx_q];
        open_d  = 1'b0;
        close_d = (idx_q == 2'd3);
      end
      dssfw_pkg::BK_DISP: begin
        emit   = 1'b1;
        pop_o  = 1'b1;
        byte_d = cfg_i.display_cmd + {4'd0, cfg_i.brightness};
        last_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dssfw_pkg::BK_DATA;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      strobe_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    open_q  <= open_d;
    close_q <= close_d;
    last_q  <= last_d;
  end

  assign strobe        = strobe_q;
  assign bus_byte_o    = byte_q;
  assign open_frame_o  = open_q;
  assign close_frame_o = close_q;
  assign last_o        = last_q;

endmodule

// File: hw/rtl/decimal_seven_segment_frame_writer_core.sv
// Channel  | Direction | Handshake                       | Payload
// request  | in        | start high while busy low       | number, flags, count, position
// config   | in        | wr_en_i high                    | wr_index_i, wr_data_i
// bus      | out       | strobe high for one cycle       | bus_byte, frame marks, last
//
// Each word yields 3 + digit_count bytes, with digit_count capped at 4, so 3 to 7 bytes per word.
// A word passes the digit pipeline, the word queue and the output register before its first byte appears.
// Words that follow each other are emitted with no gap between them when the next word is already queued.
// Busy rises only when the digit pipeline and the word queue together hold QueueDepth words.
// Reset is asynchronous and empties the pipeline, the queue and the output strobe.
// The receiver cannot stall; every byte is shown for exactly one cycle.
`include "decimal_seven_segment_frame_writer_core_macros.svh"

module decimal_seven_segment_frame_writer_core #(
  parameter int unsigned QueueDepth = dssfw_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] number_i,
  input  logic        show_leading_zeros_i,
  input  logic [2:0]  digit_count_i,
  input  logic [1:0]  first_position_i,
  input  logic        wr_en_i,
  input  logic [1:0]  wr_index_i,
  input  logic [7:0]  wr_data_i,
  output logic        strobe,
  output logic [7:0]  bus_byte_o,
  output logic        open_frame_o,
  output logic        close_frame_o,
  output logic        last_o
);

  localparam int unsigned CreditW = $clog2(QueueDepth + 1);

  dssfw_pkg::cfg_t        cfg_q, cfg_d;
  dssfw_pkg::digit_word_t push_word;
  dssfw_pkg::digit_word_t head_word;
  logic                   push;
  logic                   pop;
  logic                   not_empty;
  logic [CreditW-1:0]     credit;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        dssfw_pkg::CFG_BRIGHTNESS:  cfg_d.brightness  = wr_data_i[3:0];
        dssfw_pkg::CFG_DATA_CMD:    cfg_d.data_cmd    = wr_data_i;
        dssfw_pkg::CFG_ADDRESS_CMD: cfg_d.address_cmd = wr_data_i;
        dssfw_pkg::CFG_DISPLAY_CMD: cfg_d.display_cmd = wr_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness  <= 4'd0;
      cfg_q.data_cmd    <= 8'h40;
      cfg_q.address_cmd <= 8'hC0;
      cfg_q.display_cmd <= 8'h80;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dssfw_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .number_i            (number_i),
    .show_leading_zeros_i(show_leading_zeros_i),
    .digit_count_i       (digit_count_i),
    .first_position_i    (first_position_i),
    .pop_i               (pop),
    .push_o              (push),
    .push_word_o         (push_word),
    .credit_o            (credit)
  );

  dssfw_queue #(
    .QueueDepth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_word_i(push_word),
    .pop_i      (pop),
    .not_empty_o(not_empty),
    .head_word_o(head_word)
  );

  dssfw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .not_empty_i  (not_empty),
    .word_i       (head_word),
    .pop_o        (pop),
    .strobe       (strobe),
    .bus_byte_o   (bus_byte_o),
    .open_frame_o (open_frame_o),
    .close_frame_o(close_frame_o),
    .last_o       (last_o)
  );

  `DSSFW_ASSERT(a_credit_bound, clk_i, rst_ni, credit <= CreditW'(QueueDepth))
  `DSSFW_ASSERT(a_strobe_needs_word, clk_i, rst_ni, strobe |-> ($past(credit) != '0))
  `DSSFW_ASSERT_NEVER(a_pop_when_empty, clk_i, rst_ni, pop && !not_empty)
  `DSSFW_ASSERT(a_last_is_framed, clk_i, rst_ni, (strobe && last_o) |-> (open_frame_o && close_frame_o))

endmodule

// File: bench/frame_byte_monitor.sv
module frame_byte_monitor
  import dssfw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [15:0] number_i,
  input  logic        show_leading_zeros_i,
  input  logic [2:0]  digit_count_i,
  input  logic [1:0]  first_position_i,
  input  logic        wr_en_i,
  input  logic [1:0]  wr_index_i,
  input  logic [7:0]  wr_data_i,
  input  logic        strobe_i,
  input  logic [7:0]  bus_byte_i,
  input  logic        open_frame_i,
  input  logic        close_frame_i,
  input  logic        last_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          words_seen_o
);

  typedef struct packed {
    logic [7:0] bus_val;
    logic       open_mark;
    logic       close_mark;
    logic       final_mark;
  } bus_word_t;

  localparam logic [7:0] GLYPHS [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };
  localparam logic [7:0] BLANK_GLYPH = 8'h00;
  localparam logic [3:0] BRIGHTNESS_RESET = 4'd0;
  localparam logic [7:0] DATA_CMD_RESET = 8'h40;
  localparam logic [7:0] ADDRESS_CMD_RESET = 8'hC0;
  localparam logic [7:0] DISPLAY_CMD_RESET = 8'h80;

  logic [3:0] brightness_q;
  logic [7:0] data_cmd_q;
  logic [7:0] address_cmd_q;
  logic [7:0] display_cmd_q;
  bus_word_t  expected_words [$];
  int         mismatches = 0;
  int         words_seen = 0;

  assign mismatches_o = mismatches;
  assign pending_o    = expected_words.size();
  assign words_seen_o = words_seen;

  // Splits the number into decimal digits and queues every byte of its frame.
  function automatic void queue_frame(input logic [15:0] value, input logic keep_zeros,
                                      input logic [2:0] count_in, input logic [1:0] pos);
    int         weights [4];
    int         rest;
    int         quot;
    int         count;
    logic       leading;
    logic [7:0] segs [4];
    weights = '{1000, 100, 10, 1};
    rest    = value;
    leading = 1'b1;
    count   = (count_in > MAX_COUNT) ? NUM_DIGITS : count_in;
    for (int i = 0; i < 4; i++) begin
      quot = rest / weights[i];
      if (quot == 0) begin
        segs[i] = (keep_zeros || !leading || i == 3) ? GLYPHS[0] : BLANK_GLYPH;
      end else begin
        segs[i] = GLYPHS[quot[3:0]];
        rest    = rest - quot * weights[i];
        leading = 1'b0;
      end
    end
    expected_words.push_back('{data_cmd_q, 1'b1, 1'b1, 1'b0});
    expected_words.push_back('{8'(address_cmd_q + pos), 1'b1, count == 0, 1'b0});
    for (int i = 4 - count; i < 4; i++) begin
      expected_words.push_back('{segs[i], 1'b0, i == 3, 1'b0});
    end
    expected_words.push_back('{8'(display_cmd_q + brightness_q), 1'b1, 1'b1, 1'b1});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bus_word_t got;
    bus_word_t want;
    if (!rst_ni) begin
      brightness_q  <= BRIGHTNESS_RESET;
      data_cmd_q    <= DATA_CMD_RESET;
      address_cmd_q <= ADDRESS_CMD_RESET;
      display_cmd_q <= DISPLAY_CMD_RESET;
      expected_words.delete();
    end else begin
      if (strobe_i) begin
        got = '{bus_byte_i, open_frame_i, close_frame_i, last_i};
        if (expected_words.size() == 0) begin
          if (mismatches < 10) begin
            $display("word %0d: byte %02h (open %b close %b last %b) with nothing expected",
                     words_seen, got.bus_val, got.open_mark, got.close_mark,
                     got.final_mark);
          end
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (got.bus_val !== want.bus_val || got.open_mark !== want.open_mark ||
              got.close_mark !== want.close_mark || got.final_mark !== want.final_mark) begin
            if (mismatches < 10) begin
              $display("word %0d: expected %02h open %b close %b last %b, got %02h open %b close %b last %b",
                       words_seen, want.bus_val, want.open_mark, want.close_mark,
                       want.final_mark, got.bus_val, got.open_mark, got.close_mark,
                       got.final_mark);
            end
            mismatches++;
          end
        end
        words_seen++;
      end
      if (start_i && !busy_i) begin
        queue_frame(number_i, show_leading_zeros_i, digit_count_i, first_position_i);
      end
      if (wr_en_i) begin
        case (wr_index_i)
          CFG_BRIGHTNESS:  brightness_q  <= wr_data_i[3:0];
          CFG_DATA_CMD:    data_cmd_q    <= wr_data_i;
          CFG_ADDRESS_CMD: address_cmd_q <= wr_data_i;
          CFG_DISPLAY_CMD: display_cmd_q <= wr_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: bench/tb.sv
module tb;
  import dssfw_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int BLOCKS = 10;
  localparam int BLOCK_WORDS = 50;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] number_i = '0;
  logic        show_leading_zeros_i = 1'b0;
  logic [2:0]  digit_count_i = 3'd1;
  logic [1:0]  first_position_i = '0;
  logic        wr_en_i = 1'b0;
  logic [1:0]  wr_index_i = CFG_BRIGHTNESS;
  logic [7:0]  wr_data_i = '0;
  logic        strobe;
  logic [7:0]  bus_byte_o;
  logic        open_frame_o;
  logic        close_frame_o;
  logic        last_o;
  int          mismatches;
  int          pending;
  int          words_seen;
  int          requests_sent = 0;
  int          settings_used = 1;
  int          stall_cycles = 0;

  decimal_seven_segment_frame_writer_core uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .number_i             (number_i),
    .show_leading_zeros_i (show_leading_zeros_i),
    .digit_count_i        (digit_count_i),
    .first_position_i     (first_position_i),
    .wr_en_i              (wr_en_i),
    .wr_index_i           (wr_index_i),
    .wr_data_i            (wr_data_i),
    .strobe               (strobe),
    .bus_byte_o           (bus_byte_o),
    .open_frame_o         (open_frame_o),
    .close_frame_o        (close_frame_o),
    .last_o               (last_o)
  );

  frame_byte_monitor monitor (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start),
    .busy_i               (busy),
    .number_i             (number_i),
    .show_leading_zeros_i (show_leading_zeros_i),
    .digit_count_i        (digit_count_i),
    .first_position_i     (first_position_i),
    .wr_en_i              (wr_en_i),
    .wr_index_i           (wr_index_i),
    .wr_data_i            (wr_data_i),
    .strobe_i             (strobe),
    .bus_byte_i           (bus_byte_o),
    .open_frame_i         (open_frame_o),
    .close_frame_i        (close_frame_o),
    .last_i               (last_o),
    .mismatches_o         (mismatches),
    .pending_o            (pending),
    .words_seen_o         (words_seen)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || strobe || wr_en_i) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Busy only changes at rising edges, so a low busy seen at the falling edge
  // means the word is taken at the next rising edge.
  task automatic send_request(input logic [15:0] value, input logic keep_zeros,
                              input logic [2:0] count, input logic [1:0] pos);
    @(negedge clk_i);
    start                <= 1'b1;
    number_i             <= value;
    show_leading_zeros_i <= keep_zeros;
    digit_count_i        <= count;
    first_position_i     <= pos;
    while (busy) @(negedge clk_i);
    requests_sent++;
  endtask

  task automatic sender_pause(input int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    wr_en_i    <= 1'b1;
    wr_index_i <= idx;
    wr_data_i  <= val;
  endtask

  task automatic load_setting(input logic [7:0] bright, input logic [7:0] data_cmd,
                              input logic [7:0] addr_cmd, input logic [7:0] disp_cmd);
    drain();
    write_reg(CFG_BRIGHTNESS, bright);
    write_reg(CFG_DATA_CMD, data_cmd);
    write_reg(CFG_ADDRESS_CMD, addr_cmd);
    write_reg(CFG_DISPLAY_CMD, disp_cmd);
    @(negedge clk_i);
    wr_en_i <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int          pct;
    logic [15:0] value;
    logic [2:0]  count;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_request(16'd0, 1'b0, 3'd4, 2'd0);
    send_request(16'd0, 1'b1, 3'd4, 2'd1);
    send_request(16'd65535, 1'b0, 3'd4, 2'd2);
    send_request(16'd65535, 1'b1, 3'd4, 2'd3);
    send_request(16'd16000, 1'b0, 3'd4, 2'd0);
    send_request(16'd16005, 1'b0, 3'd4, 2'd0);
    send_request(16'd10000, 1'b0, 3'd4, 2'd0);
    send_request(16'd11111, 1'b0, 3'd4, 2'd1);
    send_request(16'd12345, 1'b0, 3'd3, 2'd2);
    send_request(16'd13999, 1'b1, 3'd4, 2'd3);
    send_request(16'd14000, 1'b0, 3'd2, 2'd0);
    send_request(16'd15999, 1'b0, 3'd4, 2'd1);
    send_request(16'd9999, 1'b0, 3'd4, 2'd0);
    send_request(16'd1000, 1'b0, 3'd4, 2'd0);
    send_request(16'd100, 1'b0, 3'd4, 2'd0);
    send_request(16'd7, 1'b0, 3'd4, 2'd0);
    send_request(16'd5, 1'b1, 3'd4, 2'd0);
    send_request(16'd42, 1'b0, 3'd0, 2'd2);
    send_request(16'd42, 1'b0, 3'd5, 2'd1);
    send_request(16'd8080, 1'b1, 3'd6, 2'd3);
    send_request(16'd305, 1'b0, 3'd7, 2'd0);
    send_request(16'd1, 1'b0, 3'd1, 2'd3);
    send_request(16'd1234, 1'b0, 3'd2, 2'd3);
    send_request(16'd65535, 1'b0, 3'd1, 2'd0);

    for (int blk = 0; blk < BLOCKS; blk++) begin
      if (blk == 0) begin
        load_setting(8'h00, 8'h00, 8'h00, 8'h00);
      end else if (blk == 1) begin
        load_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      end else begin
        load_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
      pct = (blk < BLOCKS / 3) ? 24 : (blk < 2 * BLOCKS / 3) ? 76 : 0;
      for (int n = 0; n < BLOCK_WORDS; n++) begin
        case ($urandom_range(3))
          0: value = 16'($urandom);
          1: value = 16'($urandom_range(9999));
          2: value = 16'($urandom_range(99));
          default: value = 16'($urandom_range(65535, 10000));
        endcase
        if ($urandom_range(9) < 8) begin
          count = 3'($urandom_range(4, 1));
        end else begin
          count = 3'($urandom);
        end
        sender_pause(pct);
        send_request(value, 1'($urandom), count, 2'($urandom));
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("Sent %0d requests under %0d register settings, %0d bus bytes checked.",
             requests_sent, settings_used, words_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
